FILE: design/ospfnsm_pkg.sv
// Shared types and constants for the OSPF neighbor state machine.
package ospfnsm_pkg;

  localparam int unsigned RouterIdW  = 32;
  localparam int unsigned LinkTypeW  = 2;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned ModeW      = 3;
  localparam int unsigned InDataW    = 104;
  localparam int unsigned OutDataW   = 16;

  typedef enum logic [2:0] {
    ST_DOWN     = 3'd0,
    ST_ATTEMPT  = 3'd1,
    ST_INIT     = 3'd2,
    ST_TWOWAY   = 3'd3,
    ST_EXSTART  = 3'd4,
    ST_EXCHANGE = 3'd5,
    ST_LOADING  = 3'd6,
    ST_FULL     = 3'd7
  } nbr_state_e;

  typedef enum logic [ModeW-1:0] {
    EV_HELLO        = 3'd0,
    EV_TWOWAY       = 3'd1,
    EV_ONEWAY       = 3'd2,
    EV_NEG_DONE     = 3'd3,
    EV_SEQ_MISMATCH = 3'd4,
    EV_EXCH_DONE    = 3'd5,
    EV_BAD_LS_REQ   = 3'd6,
    EV_LOAD_DONE    = 3'd7
  } event_e;

  typedef enum logic [LinkTypeW-1:0] {
    LINK_P2P       = 2'd0,
    LINK_BROADCAST = 2'd1,
    LINK_NBMA      = 2'd2,
    LINK_OTHER     = 2'd3
  } link_type_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_OWN_ROUTER_ID = 2'd0,
    REG_NBR_ROUTER_ID = 2'd1,
    REG_LINK_TYPE     = 2'd2,
    REG_IFACE_ADDR    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [RouterIdW-1:0] own_router_id;
    logic [RouterIdW-1:0] neighbor_router_id;
    link_type_e           link_type;
    logic [RouterIdW-1:0] interface_addr;
  } cfg_t;

  typedef struct packed {
    event_e               mode;
    logic [RouterIdW-1:0] adv_dr;
    logic [RouterIdW-1:0] adv_bdr;
    logic                 req_list_empty;
    logic [RouterIdW-1:0] link_dr;
  } item_t;

  typedef struct packed {
    logic       master_flag;
    logic       gen_network_lsa;
    logic       gen_router_lsa;
    logic       start_lsr_send;
    logic       init_summary;
    logic       start_empty_dd;
    logic       accepted;
    nbr_state_e new_state;
  } result_t;

endpackage

FILE: design/ospfnsm_cfg_regs.sv
// Configuration register file for the neighbor state machine.
module ospfnsm_cfg_regs import ospfnsm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_OWN_ROUTER_ID: cfg_d.own_router_id      = cfg_data_i;
        REG_NBR_ROUTER_ID: cfg_d.neighbor_router_id = cfg_data_i;
        REG_LINK_TYPE:     cfg_d.link_type          = link_type_e'(cfg_data_i[LinkTypeW-1:0]);
        REG_IFACE_ADDR:    cfg_d.interface_addr     = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_router_id      <= '0;
      cfg_q.neighbor_router_id <= '0;
      cfg_q.link_type          <= LINK_BROADCAST;
      cfg_q.interface_addr     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/ospfnsm_fsm.sv
// Neighbor state and master flag with the event transition logic.
module ospfnsm_fsm import ospfnsm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  nbr_state_e state_q, state_d;
  logic       master_q, master_d;
  logic       multi_access, no_role;
  logic       ok, empty_dd, summ, lsr, rlsa, nlsa;

  assign multi_access = (cfg_i.link_type == LINK_BROADCAST) ||
                        (cfg_i.link_type == LINK_NBMA);
  assign no_role = (cfg_i.neighbor_router_id != item_i.adv_dr) &&
                   (cfg_i.neighbor_router_id != item_i.adv_bdr) &&
                   (cfg_i.own_router_id != item_i.adv_dr) &&
                   (cfg_i.own_router_id != item_i.adv_bdr);

  always_comb begin
    state_d = state_q;
    unique case (item_i.mode)
      EV_HELLO: begin
        if (state_q == ST_DOWN) state_d = ST_INIT;
      end
      EV_TWOWAY: begin
        if (state_q == ST_INIT) state_d = (multi_access && no_role) ? ST_TWOWAY : ST_EXSTART;
      end
      EV_ONEWAY: begin
        if (state_q >= ST_TWOWAY) state_d = ST_INIT;
      end
      EV_NEG_DONE: begin
        if (state_q == ST_EXSTART) state_d = ST_EXCHANGE;
      end
      EV_SEQ_MISMATCH, EV_BAD_LS_REQ: begin
        if (state_q >= ST_EXCHANGE) state_d = ST_EXSTART;
      end
      EV_EXCH_DONE: begin
        if (state_q == ST_EXCHANGE) state_d = item_i.req_list_empty ? ST_FULL : ST_LOADING;
      end
      EV_LOAD_DONE: begin
        if (state_q == ST_LOADING) state_d = ST_FULL;
      end
      default: state_d = state_q;
    endcase
  end

  always_comb begin
    ok       = 1'b0;
    empty_dd = 1'b0;
    summ     = 1'b0;
    lsr      = 1'b0;
    rlsa     = 1'b0;
    nlsa     = 1'b0;
    unique case (item_i.mode)
      EV_HELLO: begin
        ok = (state_q == ST_DOWN) || (state_q >= ST_INIT);
      end
      EV_TWOWAY: begin
        ok       = (state_q == ST_INIT);
        empty_dd = (state_q == ST_INIT) && !(multi_access && no_role);
      end
      EV_ONEWAY: begin
        ok = (state_q >= ST_TWOWAY);
      end
      EV_NEG_DONE: begin
        ok   = (state_q == ST_EXSTART);
        summ = (state_q == ST_EXSTART);
      end
      EV_SEQ_MISMATCH, EV_BAD_LS_REQ: begin
        ok       = (state_q >= ST_EXCHANGE);
        empty_dd = (state_q >= ST_EXCHANGE);
      end
      EV_EXCH_DONE: begin
        ok   = (state_q == ST_EXCHANGE);
        rlsa = (state_q == ST_EXCHANGE) && item_i.req_list_empty;
        nlsa = (state_q == ST_EXCHANGE) && item_i.req_list_empty &&
               (item_i.link_dr == cfg_i.interface_addr);
        lsr  = (state_q == ST_EXCHANGE) && !item_i.req_list_empty;
      end
      EV_LOAD_DONE: begin
        ok   = (state_q == ST_LOADING);
        rlsa = (state_q == ST_LOADING);
      end
      default: ok = 1'b0;
    endcase
  end

  assign master_d = master_q | empty_dd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_DOWN;
      master_q <= 1'b0;
    end else if (step_i) begin
      state_q  <= state_d;
      master_q <= master_d;
    end
  end

  assign result_o.new_state       = state_d;
  assign result_o.accepted        = ok;
  assign result_o.start_empty_dd  = empty_dd;
  assign result_o.init_summary    = summ;
  assign result_o.start_lsr_send  = lsr;
  assign result_o.gen_router_lsa  = rlsa;
  assign result_o.gen_network_lsa = nlsa;
  assign result_o.master_flag     = master_d;

endmodule

FILE: design/ospf_neighbor_state_machine_top.sv
// Top level of the OSPF neighbor adjacency state machine.
// One neighbor event enters per transfer on the slave stream and produces exactly one result
// on the master stream; a new event is taken every cycle unless the master stream stalls,
// and each result passes through the input register, then the result register, the state
// register updating as the result is registered. The configuration port takes a write every
// cycle; the user must write it only while no event is in flight, not enforced by the block.
module ospf_neighbor_state_machine_top import ospfnsm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // adv_dr[31:0], adv_bdr[63:32], req_list_empty[64], link_dr[96:65], zero fill
  input  logic [InDataW-1:0]   s_axis_tdata,
  // mode[2:0]
  input  logic [ModeW-1:0]     s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // new_state[2:0], accepted, start_empty_dd, init_summary, start_lsr_send,
  // gen_router_lsa, gen_network_lsa, master_flag[9], zero fill
  output logic [OutDataW-1:0]  m_axis_tdata
);

  cfg_t    cfg;
  item_t   in_item, item_q;
  result_t result, result_q;
  logic    in_valid_q, out_valid_q, advance;

  assign cfg_ready_o = 1'b1;

  ospfnsm_cfg_regs u_cfg_regs (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  assign in_item.mode           = event_e'(s_axis_tuser);
  assign in_item.adv_dr         = s_axis_tdata[31:0];
  assign in_item.adv_bdr        = s_axis_tdata[63:32];
  assign in_item.req_list_empty = s_axis_tdata[64];
  assign in_item.link_dr        = s_axis_tdata[96:65];

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) item_q <= in_item;
  end

  ospfnsm_fsm u_fsm (
    .clk_i,
    .rst_ni,
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) result_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, result_q};

endmodule

FILE: test/tb_top.sv
// Testbench for the OSPF neighbor state machine: directed walks, link-type sweeps, random sessions.
`timescale 1ns / 100ps

module tb_top import ospfnsm_pkg::*; ();

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned RandomPhases = 5;
  localparam int unsigned PhaseItems   = 98;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic [ModeW-1:0]     s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;

  ospf_neighbor_state_machine_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // adjacency model state and register copies
  nbr_state_e           model_state;
  logic                 model_master;
  logic [RouterIdW-1:0] cfg_own_id;
  logic [RouterIdW-1:0] cfg_nbr_id;
  logic [RouterIdW-1:0] cfg_iface;
  link_type_e           cfg_link;

  result_t     pending_results[$];
  result_t     want_result;
  result_t     got_result;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned rx_cycle;
  int unsigned burst_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic result_t adjacency_step(event_e ev, logic [RouterIdW-1:0] dr,
                                             logic [RouterIdW-1:0] bdr, logic req_empty,
                                             logic [RouterIdW-1:0] cur_dr);
    result_t    r;
    nbr_state_e s;
    logic       multi;
    logic       no_role;
    r       = '0;
    s       = model_state;
    multi   = (cfg_link == LINK_BROADCAST) || (cfg_link == LINK_NBMA);
    no_role = (cfg_nbr_id != dr) && (cfg_nbr_id != bdr) && (cfg_own_id != dr) &&
              (cfg_own_id != bdr);
    case (ev)
      EV_HELLO: begin
        if (s == ST_DOWN) begin
          s          = ST_INIT;
          r.accepted = 1'b1;
        end else if (s >= ST_INIT) begin
          r.accepted = 1'b1;
        end
      end
      EV_TWOWAY: begin
        if (s == ST_INIT) begin
          r.accepted = 1'b1;
          if (multi && no_role) begin
            s = ST_TWOWAY;
          end else begin
            s                = ST_EXSTART;
            r.start_empty_dd = 1'b1;
            model_master     = 1'b1;
          end
        end
      end
      EV_ONEWAY: begin
        if (s >= ST_TWOWAY) begin
          s          = ST_INIT;
          r.accepted = 1'b1;
        end
      end
      EV_NEG_DONE: begin
        if (s == ST_EXSTART) begin
          s              = ST_EXCHANGE;
          r.init_summary = 1'b1;
          r.accepted     = 1'b1;
        end
      end
      EV_SEQ_MISMATCH, EV_BAD_LS_REQ: begin
        if (s >= ST_EXCHANGE) begin
          s                = ST_EXSTART;
          r.start_empty_dd = 1'b1;
          model_master     = 1'b1;
          r.accepted       = 1'b1;
        end
      end
      EV_EXCH_DONE: begin
        if (s == ST_EXCHANGE) begin
          r.accepted = 1'b1;
          if (req_empty) begin
            s                 = ST_FULL;
            r.gen_router_lsa  = 1'b1;
            r.gen_network_lsa = (cur_dr == cfg_iface);
          end else begin
            s                = ST_LOADING;
            r.start_lsr_send = 1'b1;
          end
        end
      end
      default: begin
        if (s == ST_LOADING) begin
          s                = ST_FULL;
          r.gen_router_lsa = 1'b1;
          r.accepted       = 1'b1;
        end
      end
    endcase
    model_state  = s;
    r.new_state  = s;
    r.master_flag = model_master;
    return r;
  endfunction

  task automatic send_event(event_e ev, logic [RouterIdW-1:0] dr, logic [RouterIdW-1:0] bdr,
                            logic req_empty, logic [RouterIdW-1:0] cur_dr);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      gap        = $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev;
    s_axis_tdata  <= {7'b0, cur_dr, req_empty, bdr, dr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.insert(pending_results.size(),
                           adjacency_step(ev, dr, bdr, req_empty, cur_dr));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_OWN_ROUTER_ID: cfg_own_id = val;
      REG_NBR_ROUTER_ID: cfg_nbr_id = val;
      REG_LINK_TYPE:     cfg_link   = link_type_e'(val[LinkTypeW-1:0]);
      default:           cfg_iface  = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [31:0] own_id, logic [31:0] nbr_id, logic [31:0] link_val,
                           logic [31:0] iface);
    wait_drained();
    write_reg(REG_OWN_ROUTER_ID, own_id);
    write_reg(REG_NBR_ROUTER_ID, nbr_id);
    write_reg(REG_LINK_TYPE, link_val);
    write_reg(REG_IFACE_ADDR, iface);
  endtask

  function automatic logic [31:0] pick_id_value();
    case ($urandom_range(0, 6))
      0, 1:    return cfg_own_id;
      2:       return cfg_nbr_id;
      3:       return 32'h0;
      4:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_free_id();
    logic [31:0] v;
    v = $urandom;
    while (v == cfg_own_id || v == cfg_nbr_id) v = $urandom;
    return v;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly protocol-shaped events, some noise
  function automatic event_e pick_event();
    if ($urandom_range(0, 99) < 15) return event_e'($urandom_range(0, 7));
    case (model_state)
      ST_DOWN:     return EV_HELLO;
      ST_INIT:     return ($urandom_range(0, 4) == 0) ? EV_HELLO : EV_TWOWAY;
      ST_TWOWAY:   return ($urandom_range(0, 2) == 0) ? EV_HELLO : EV_ONEWAY;
      ST_EXSTART:  return EV_NEG_DONE;
      ST_EXCHANGE: begin
        case ($urandom_range(0, 7))
          0:       return EV_SEQ_MISMATCH;
          1:       return EV_BAD_LS_REQ;
          default: return EV_EXCH_DONE;
        endcase
      end
      ST_LOADING:  begin
        case ($urandom_range(0, 7))
          0:       return EV_SEQ_MISMATCH;
          1:       return EV_BAD_LS_REQ;
          default: return EV_LOAD_DONE;
        endcase
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return EV_ONEWAY;
          1:       return EV_SEQ_MISMATCH;
          2:       return EV_BAD_LS_REQ;
          default: return EV_HELLO;
        endcase
      end
    endcase
  endfunction

  task automatic test_directed_walk();
    send_event(EV_TWOWAY, 32'h1, 32'h2, 1'b0, 32'h0);
    send_event(EV_ONEWAY, 32'h0, 32'h0, 1'b1, 32'h0);
    send_event(EV_LOAD_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_event(EV_HELLO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_event(EV_HELLO, 32'h0, 32'h0, 1'b0, 32'h0);
    send_event(EV_TWOWAY, 32'hFFFF_FFFF, 32'h1, 1'b0, 32'h0);
    send_event(EV_HELLO, 32'h5, 32'h6, 1'b0, 32'h7);
    send_event(EV_NEG_DONE, 32'h5, 32'h6, 1'b0, 32'h7);
    send_event(EV_ONEWAY, 32'h5, 32'h6, 1'b0, 32'h7);
    send_event(EV_TWOWAY, 32'h0, 32'h1234_5678, 1'b0, 32'h0);
    send_event(EV_NEG_DONE, 32'h0, 32'h0, 1'b0, 32'h0);
    send_event(EV_EXCH_DONE, 32'h0, 32'h0, 1'b0, 32'h0);
    send_event(EV_LOAD_DONE, 32'h0, 32'h0, 1'b0, 32'h0);
    send_event(EV_SEQ_MISMATCH, 32'h0, 32'h0, 1'b0, 32'h0);
    send_event(EV_NEG_DONE, 32'h0, 32'h0, 1'b0, 32'h0);
    send_event(EV_EXCH_DONE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'h0);
    send_event(EV_BAD_LS_REQ, 32'h0, 32'h0, 1'b1, 32'h0);
    send_event(EV_NEG_DONE, 32'h0, 32'h0, 1'b1, 32'h0);
    send_event(EV_EXCH_DONE, 32'h0, 32'h0, 1'b1, 32'hFFFF_FFFF);
    send_event(EV_ONEWAY, 32'h0, 32'h0, 1'b1, 32'h0);
    send_event(EV_LOAD_DONE, 32'h0, 32'h0, 1'b1, 32'h0);
    send_event(EV_EXCH_DONE, 32'h0, 32'h0, 1'b1, 32'h0);
    send_event(EV_SEQ_MISMATCH, 32'h0, 32'h0, 1'b1, 32'h0);
    send_event(EV_BAD_LS_REQ, 32'h0, 32'h0, 1'b1, 32'h0);
  endtask

  task automatic test_link_types();
    link_type_e kinds[4];
    kinds = '{LINK_P2P, LINK_BROADCAST, LINK_NBMA, LINK_OTHER};
    foreach (kinds[k]) begin
      case (k)
        0:       configure(32'h0, 32'hFFFF_FFFF, kinds[k], 32'hFFFF_FFFF);
        3:       configure(32'hFFFF_FFFF, 32'h0, kinds[k], 32'h0);
        default: configure($urandom, $urandom, kinds[k], $urandom);
      endcase
      send_event(EV_ONEWAY, $urandom, $urandom, 1'b0, $urandom);
      send_event(EV_HELLO, $urandom, $urandom, 1'b0, $urandom);
      send_event(EV_TWOWAY, pick_free_id(), pick_free_id(), 1'b0, $urandom);
      send_event(EV_ONEWAY, $urandom, $urandom, 1'b0, $urandom);
      send_event(EV_TWOWAY, pick_free_id(), cfg_nbr_id, 1'b0, $urandom);
      send_event(EV_ONEWAY, $urandom, $urandom, 1'b0, $urandom);
      send_event(EV_TWOWAY, cfg_own_id, pick_free_id(), 1'b0, $urandom);
      send_event(EV_NEG_DONE, $urandom, $urandom, 1'b0, $urandom);
      send_event(EV_EXCH_DONE, $urandom, $urandom, 1'b1, cfg_iface);
    end
  endtask

  task automatic test_random_sessions();
    event_e ev;
    for (int p = 0; p < RandomPhases; p++) begin
      configure(pick_extreme(), pick_extreme(), $urandom_range(0, 3), pick_extreme());
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 2 && n == PhaseItems / 2) wait_drained();
        ev = pick_event();
        send_event(ev, pick_id_value(), pick_id_value(), $urandom_range(0, 1),
                   ($urandom_range(0, 1) != 0) ? cfg_iface : $urandom);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_OWN_ROUTER_ID;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = EV_HELLO;
    model_state   = ST_DOWN;
    model_master  = 1'b0;
    cfg_own_id    = '0;
    cfg_nbr_id    = '0;
    cfg_iface     = '0;
    cfg_link      = LINK_BROADCAST;
    burst_left    = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_walk();
    test_link_types();
    test_random_sessions();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver backpressure: rotate through ready patterns
  initial begin
    m_axis_tready = 1'b0;
    rx_cycle      = 0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      case ((rx_cycle / 150) % 4)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready <= ((rx_cycle % 7) < 4);
        default: m_axis_tready <= $urandom_range(0, 1);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_result = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("unexpected result transfer: %h", m_axis_tdata);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.new_state !== want_result.new_state ||
            got_result.accepted !== want_result.accepted ||
            got_result.start_empty_dd !== want_result.start_empty_dd ||
            got_result.init_summary !== want_result.init_summary ||
            got_result.start_lsr_send !== want_result.start_lsr_send ||
            got_result.gen_router_lsa !== want_result.gen_router_lsa ||
            got_result.gen_network_lsa !== want_result.gen_network_lsa ||
            got_result.master_flag !== want_result.master_flag) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("result mismatch: expected %b got %b", want_result, got_result);
        end
      end
    end
  end

  initial begin
    cycle_count    = 0;
    mismatch_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
